// ===== rtl/keyword_syntax_classifier_macros.svh =====
// Assertion macros used by the classifier window module.
`ifndef KEYWORD_SYNTAX_CLASSIFIER_MACROS_SVH
`define KEYWORD_SYNTAX_CLASSIFIER_MACROS_SVH

`define KSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define KSC_NEVER(label, cond, msg) \
  `KSC_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/ksc_pkg.sv =====
`default_nettype none

package ksc_pkg;

  localparam int LOOKAHEAD_DEPTH = 8;
  localparam int WIN_IDX_W       = $clog2(LOOKAHEAD_DEPTH);
  localparam int FILL_W          = $clog2(LOOKAHEAD_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int KW_COUNT   = 9;
  localparam int KW_MAX_LEN = 7;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;

  typedef struct packed {
    logic [7:0] ch;
    logic       cursor;
    logic       last;
    logic       alpha;
    logic       digit;
    logic       quote;
  } ksc_item_t;

  typedef enum logic [2:0] {
    CLS_DEFAULT,
    CLS_KEYWORD,
    CLS_NUMBER,
    CLS_STRING,
    CLS_CURSOR
  } ksc_class_t;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "c", "l", "u", "d", "e"}
  };

  localparam logic [WIN_IDX_W-1:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4, 3'd4, 3'd7
  };

endpackage

`default_nettype wire

// ===== rtl/keyword_syntax_classifier.sv =====
// A beat passes the front register, queue, window and output register; a letter that may
// open a keyword waits until the keyword is settled by a following character or line end.
// The window moves one beat per cycle unless a letter awaits a keyword, output stalls or the
// window drains at line end. A four-entry queue lets input and output stall independently.
// Reset (rst, synchronous, active high) empties the window, queue and output register.
`default_nettype none

module keyword_syntax_classifier import ksc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // character
  input  wire logic        s_axis_tuser,   // at_cursor
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // out_character, color_class, zero fill
  output logic             m_axis_tlast
);

  logic       fr_valid;
  logic       fr_ready;
  ksc_item_t  fr_item;
  logic       q_valid;
  logic       q_ready;
  ksc_item_t  q_item;
  logic [7:0] out_character;
  logic [2:0] out_class;

  ksc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_character (s_axis_tdata),
    .in_at_cursor (s_axis_tuser),
    .in_line_end  (s_axis_tlast),
    .q_valid      (fr_valid),
    .q_ready      (fr_ready),
    .q_item       (fr_item)
  );

  ksc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  ksc_window u_window (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_character (out_character),
    .out_class     (out_class),
    .out_done      (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_class, out_character};

endmodule

`default_nettype wire

// ===== rtl/ksc_front.sv =====
`default_nettype none

module ksc_front import ksc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_character,
  input  wire logic       in_at_cursor,
  input  wire logic       in_line_end,
  output logic            q_valid,
  input  wire logic       q_ready,
  output ksc_item_t       q_item
);

  logic      valid;
  ksc_item_t item;
  ksc_item_t item_next;

  always_comb begin
    item_next.ch     = in_character;
    item_next.cursor = in_at_cursor;
    item_next.last   = in_line_end;
    item_next.alpha  = (in_character >= 8'h41 && in_character <= 8'h5a) ||
                       (in_character >= 8'h61 && in_character <= 8'h7a);
    item_next.digit  = in_character >= 8'h30 && in_character <= 8'h39;
    item_next.quote  = in_character == QUOTE_CHAR;
  end

  assign in_ready = !valid || q_ready;
  assign q_valid  = valid;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ksc_queue.sv =====
`default_nettype none

module ksc_queue import ksc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ksc_item_t  in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ksc_item_t       out_item
);

  ksc_item_t                slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;
  logic                     push;
  logic                     pop;

  assign in_ready  = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ksc_window.sv =====
`default_nettype none
`include "keyword_syntax_classifier_macros.svh"

module ksc_window import ksc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire ksc_item_t  q_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_character,
  output logic [2:0]      out_class,
  output logic            out_done
);

  ksc_item_t              win [LOOKAHEAD_DEPTH];
  logic [FILL_W-1:0]      fill;
  logic                   end_pending;
  logic                   in_string;
  logic                   in_number;
  logic                   prev_alnum;
  logic [WIN_IDX_W-1:0]   kw_rem;
  ksc_class_t             out_cls;

  ksc_item_t              head;
  logic                   final_win;
  logic                   kw_wait;
  logic [WIN_IDX_W-1:0]   kw_found;
  logic                   hold;
  ksc_class_t             cls;
  logic                   in_string_next;
  logic                   in_number_next;
  logic [WIN_IDX_W-1:0]   kw_rem_next;
  logic                   decidable;
  logic                   emit;
  logic                   last_char;
  logic                   take;
  logic [WIN_IDX_W-1:0]   wr_idx;
  logic                   line_busy;

  assign head      = win[0];
  assign final_win = end_pending || fill == FILL_W'(LOOKAHEAD_DEPTH);

  // Match every keyword against the window head in parallel.
  always_comb begin
    logic hit;
    logic waiting;
    logic stop;
    kw_wait  = 1'b0;
    kw_found = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit     = 1'b1;
      waiting = 1'b0;
      stop    = 1'b0;
      for (int p = 0; p < KW_MAX_LEN; p++) begin
        if (!stop && p < int'(KW_LEN[k])) begin
          if (FILL_W'(p) >= fill) begin
            if (final_win) begin
              hit = 1'b0;
            end else begin
              waiting = 1'b1;
            end
            stop = 1'b1;
          end else if (win[p].ch != KW_TEXT[k][p]) begin
            hit  = 1'b0;
            stop = 1'b1;
          end
        end
      end
      if (waiting) begin
        kw_wait = 1'b1;
      end else if (hit && kw_found == '0) begin
        if (FILL_W'(KW_LEN[k]) < fill) begin
          if (!(win[KW_LEN[k]].alpha || win[KW_LEN[k]].digit)) begin
            kw_found = KW_LEN[k];
          end
        end else if (final_win) begin
          kw_found = KW_LEN[k];
        end else begin
          kw_wait = 1'b1;
        end
      end
    end
  end

  always_comb begin
    hold           = 1'b0;
    cls            = CLS_DEFAULT;
    in_string_next = in_string;
    in_number_next = in_number;
    kw_rem_next    = kw_rem;
    if (kw_rem != '0) begin
      cls         = CLS_KEYWORD;
      kw_rem_next = kw_rem - 1'b1;
    end else begin
      in_number_next = in_number && head.digit;
      if (in_string) begin
        cls = CLS_STRING;
        if (head.quote) begin
          in_string_next = 1'b0;
        end
      end else if (in_number && head.digit) begin
        cls = CLS_NUMBER;
      end else if (head.cursor) begin
        cls = CLS_CURSOR;
      end else if (head.alpha) begin
        if (!prev_alnum) begin
          if (kw_found != '0) begin
            cls         = CLS_KEYWORD;
            kw_rem_next = kw_found - 1'b1;
          end else if (kw_wait) begin
            hold = 1'b1;
          end
        end
      end else if (head.digit) begin
        cls            = CLS_NUMBER;
        in_number_next = 1'b1;
      end else if (head.quote) begin
        cls            = CLS_STRING;
        in_string_next = 1'b1;
      end
    end
  end

  assign decidable = fill != '0 && !hold;
  assign emit      = decidable && (!out_valid || out_ready);
  assign last_char = end_pending && fill == FILL_W'(1);
  assign q_ready   = (fill < FILL_W'(LOOKAHEAD_DEPTH) || emit) &&
                     (!end_pending || (emit && last_char));
  assign take      = q_valid && q_ready;
  assign wr_idx    = WIN_IDX_W'(fill - FILL_W'(emit));
  assign line_busy = kw_rem != '0 || in_string || in_number || prev_alnum;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      end_pending <= 1'b0;
      in_string   <= 1'b0;
      in_number   <= 1'b0;
      prev_alnum  <= 1'b0;
      kw_rem      <= '0;
      out_valid   <= 1'b0;
    end else begin
      fill <= fill - FILL_W'(emit) + FILL_W'(take);
      if (take) begin
        end_pending <= q_item.last;
      end else if (emit && last_char) begin
        end_pending <= 1'b0;
      end
      if (emit) begin
        in_string  <= in_string_next && !last_char;
        in_number  <= in_number_next && !last_char;
        prev_alnum <= (head.alpha || head.digit) && !last_char;
        kw_rem     <= last_char ? '0 : kw_rem_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LOOKAHEAD_DEPTH - 1; i++) begin
      if (take && WIN_IDX_W'(i) == wr_idx) begin
        win[i] <= q_item;
      end else if (emit) begin
        win[i] <= win[i + 1];
      end
    end
    if (take && wr_idx == WIN_IDX_W'(LOOKAHEAD_DEPTH - 1)) begin
      win[LOOKAHEAD_DEPTH - 1] <= q_item;
    end
    if (emit) begin
      out_character <= head.ch;
      out_cls       <= cls;
      out_done      <= last_char;
    end
  end

  assign out_class = out_cls;

  `KSC_ASSERT(a_fill_bound, fill <= FILL_W'(LOOKAHEAD_DEPTH), "window fill beyond its depth")
  `KSC_ASSERT(a_full_decides, fill == FILL_W'(LOOKAHEAD_DEPTH) |-> decidable, "full window stuck")
  `KSC_NEVER(a_kw_exclusive, kw_rem != '0 && (in_string || in_number), "keyword inside token")
  `KSC_ASSERT(a_kw_in_window, kw_rem != '0 |-> fill != '0, "keyword tail missing from window")
  `KSC_ASSERT(a_line_clears, emit && last_char |=> !line_busy, "line state not cleared")

endmodule

`default_nettype wire
